FILE: rtl/core/pbcl_pkg.sv
// Shared constants, types and helpers for the pattern block chain length unit.
package pbcl_pkg;

	// Point store capacity and derived widths
	localparam int MAX_POINTS = 256;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Heights, depths and table widths
	localparam int HGT_W   = 8;
	localparam int HEIGHTS = 2 ** HGT_W;
	localparam int DEPTH_W = 8;
	localparam int TIDX_W  = $clog2(HEIGHTS + 1);
	localparam int PEND_AW = IDX_W + HGT_W;
	localparam int REG_W   = 2;

	localparam logic [DEPTH_W-1:0] DEPTH_TOP = '1;

	// Configuration register indexes
	localparam logic [REG_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [REG_W-1:0] CFG_FIRST_RANK     = 2'd1;
	localparam logic [REG_W-1:0] CFG_SECOND_RANK    = 2'd2;
	localparam logic [REG_W-1:0] CFG_THIRD_RANK     = 2'd3;

	// Register codes and reset values
	localparam logic [REG_W-1:0] PAT_TRIPLE  = 2'd3;
	localparam logic [REG_W-1:0] RANK_DESC   = 2'd2;
	localparam logic [REG_W-1:0] RST_PATTERN = 2'd2;
	localparam logic [REG_W-1:0] RST_FIRST   = 2'd2;
	localparam logic [REG_W-1:0] RST_SECOND  = 2'd1;
	localparam logic [REG_W-1:0] RST_THIRD   = 2'd3;

	// Main sequencer states
	typedef enum logic [4:0] {
		S_INIT,
		S_LOAD,
		S_BEGIN,
		S_SW_RD,
		S_SW_CHK,
		S_SW_WAIT,
		S_A_RD,
		S_A_GET,
		S_B_RD,
		S_B_GET,
		S_C_RD,
		S_C_GET,
		S_Q_GO,
		S_Q_WAIT,
		S_PD_RD,
		S_PD_UPD,
		S_CLR,
		S_DONE
	} state_t;

	// Prefix-max tree walker states
	typedef enum logic [1:0] {
		T_IDLE,
		T_RD,
		T_UPD
	} tstate_t;

	// Command to the prefix-max tree
	typedef struct packed {
		logic               clr;
		logic               go;
		logic               raise;
		logic [TIDX_W-1:0]  idx;
		logic [DEPTH_W-1:0] depth;
	} tree_cmd_t;

	// Response from the prefix-max tree
	typedef struct packed {
		logic               done;
		logic [DEPTH_W-1:0] result;
	} tree_rsp_t;

	// Rank of v among three heights: 1 plus the count of strictly lower others
	function automatic logic [REG_W-1:0] rank_of(logic [HGT_W-1:0] v,
			logic [HGT_W-1:0] o1, logic [HGT_W-1:0] o2);
		logic [REG_W-1:0] r;
		r = 2'd1;
		if (v > o1) r = r + 2'd1;
		if (v > o2) r = r + 2'd1;
		return r;
	endfunction

endpackage

FILE: rtl/core/pbcl_tree.sv
// Fenwick prefix-max tree over heights, held in a synchronous memory.
module pbcl_tree
	import pbcl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  tree_cmd_t cmd,
	output tree_rsp_t rsp
);

	logic [DEPTH_W-1:0] mem [0:HEIGHTS];
	logic [DEPTH_W-1:0] rd_q;
	logic [HEIGHTS:0]   vld_q;
	tstate_t            state_q, state_d;
	logic [TIDX_W-1:0]  idx_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] acc_q;
	logic               raise_q;

	logic [TIDX_W-1:0]  lowbit;
	logic [TIDX_W:0]    up_next;
	logic [TIDX_W-1:0]  down_next;
	logic [DEPTH_W-1:0] cur;
	logic [DEPTH_W-1:0] acc_max;
	logic               last_step;
	logic               zero_query;

	// Walk arithmetic
	assign lowbit     = idx_q & (~idx_q + TIDX_W'(1));
	assign up_next    = {1'b0, idx_q} + {1'b0, lowbit};
	assign down_next  = idx_q - lowbit;
	assign cur        = vld_q[idx_q] ? rd_q : '0;
	assign acc_max    = (cur > acc_q) ? cur : acc_q;
	assign last_step  = raise_q ? (up_next > (TIDX_W + 1)'(HEIGHTS)) : (down_next == '0);
	assign zero_query = cmd.go && !cmd.raise && (cmd.idx == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: begin
				if (cmd.go && !zero_query) state_d = T_RD;
			end
			T_RD: state_d = T_UPD;
			T_UPD: begin
				state_d = last_step ? T_IDLE : T_RD;
			end
			default: state_d = T_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		rsp.done   = 1'b0;
		rsp.result = '0;
		case (state_q)
			T_IDLE: rsp.done = zero_query;
			T_UPD: begin
				rsp.done   = last_step;
				rsp.result = acc_max;
			end
			default: ;
		endcase
	end

	// Control registers and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == T_IDLE && cmd.clr) vld_q <= '0;
			else if (state_q == T_UPD && raise_q && cur < depth_q) vld_q[idx_q] <= 1'b1;
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && cmd.go) begin
			idx_q   <= cmd.idx;
			depth_q <= cmd.depth;
			raise_q <= cmd.raise;
			acc_q   <= '0;
		end else if (state_q == T_UPD) begin
			acc_q <= acc_max;
			idx_q <= raise_q ? up_next[TIDX_W-1:0] : down_next;
		end
	end

	// Tree memory
	always_ff @(posedge clk) begin
		if (state_q == T_RD) rd_q <= mem[idx_q];
		if (state_q == T_UPD && raise_q && cur < depth_q) mem[idx_q] <= depth_q;
	end

`ifndef SYNTHESIS
	a_rd_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_RD |=> state_q == T_UPD)
		else $error("tree read not followed by update");
	a_no_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_RD |-> idx_q != '0)
		else $error("tree walk reached index zero");
	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> state_q == T_IDLE)
		else $error("tree command while walking");
`endif

endmodule

FILE: rtl/core/pattern_block_chain_length_unit.sv
// Top level: point loader, chain search sequencer, point and pending memories.
//
//  channel   signals                                  handshake
//  config    cfg_we, cfg_idx, cfg_wdata               write when cfg_we high
//  input     point_height, last_point                 start high, busy low
//  result    longest_chain, too_many_points           done strobe, one cycle
//
// Points load one per cycle while busy is low. An item with last_point set starts the search,
// which holds busy high through a pending-row sweep before each later start position, raising
// each pending depth into the tree, a point read per start position and per candidate block
// (n^2/2 pairs or n^3/6 triples), a tree query and pending-memory update per matched block,
// and finally a clear of the last pending row.
// After reset a clearing pass over the whole pending memory runs with busy high.
// The receiver cannot stall: the result is shown for one cycle with done.
module pattern_block_chain_length_unit
	import pbcl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [REG_W-1:0]   cfg_idx,
	input  logic [REG_W-1:0]   cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [HGT_W-1:0]   point_height,
	input  logic               last_point,
	output logic               done,
	output logic [DEPTH_W-1:0] longest_chain,
	output logic               too_many_points
);

	state_t state_q, state_d;

	logic [REG_W-1:0]   pat_len_q, rank1_q, rank2_q, rank3_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [DEPTH_W-1:0] best_q;
	logic [IDX_W-1:0]   a_q, b_q, c_q, end_q;
	logic [HGT_W-1:0]   t_q, ya_q, yb_q, lo_q, hi_q;
	logic [DEPTH_W-1:0] d_q;
	logic [PEND_AW-1:0] init_q;

	logic [HGT_W-1:0]   pt_mem [0:MAX_POINTS-1];
	logic [HGT_W-1:0]   pt_rd_q;
	logic [DEPTH_W-1:0] pd_mem [0:2**PEND_AW-1];
	logic [DEPTH_W-1:0] pd_rd_q;

	logic               pt_rd_en;
	logic [IDX_W-1:0]   pt_rd_addr;
	logic               pd_rd_en;
	logic [PEND_AW-1:0] pd_rd_addr;
	logic               pd_we;
	logic [PEND_AW-1:0] pd_wr_addr;
	logic [DEPTH_W-1:0] pd_wr_data;

	tree_cmd_t tcmd;
	tree_rsp_t trsp;

	logic               accept;
	logic               triple, desc;
	logic               a_more, b_more, c_more;
	logic [IDX_W-1:0]   n_last, row_prev;
	logic               pair_hit, trip_hit;
	logic [HGT_W-1:0]   p_lo, p_hi, t_lo, t_hi, m_ab, x_ab;
	logic [DEPTH_W-1:0] d_new;

	assign accept   = start && !busy;
	assign busy     = state_q != S_LOAD;
	assign triple   = pat_len_q == PAT_TRIPLE;
	assign desc     = rank1_q == RANK_DESC;
	assign a_more   = (CNT_W'(a_q) + CNT_W'(1)) < cnt_q;
	assign b_more   = (CNT_W'(b_q) + CNT_W'(1)) < cnt_q;
	assign c_more   = (CNT_W'(c_q) + CNT_W'(1)) < cnt_q;
	assign n_last   = IDX_W'(cnt_q - CNT_W'(1));
	assign row_prev = a_q - IDX_W'(1);
	assign d_new    = (trsp.result == DEPTH_TOP) ? DEPTH_TOP : trsp.result + DEPTH_W'(1);

	// Block matching on the freshly read point
	assign pair_hit = desc ? (pt_rd_q < ya_q) : (pt_rd_q > ya_q);
	assign p_lo     = (ya_q < pt_rd_q) ? ya_q : pt_rd_q;
	assign p_hi     = (ya_q < pt_rd_q) ? pt_rd_q : ya_q;
	assign trip_hit = rank_of(ya_q, yb_q, pt_rd_q) == rank1_q
		&& rank_of(yb_q, ya_q, pt_rd_q) == rank2_q
		&& rank_of(pt_rd_q, ya_q, yb_q) == rank3_q;
	assign m_ab     = (ya_q < yb_q) ? ya_q : yb_q;
	assign x_ab     = (ya_q > yb_q) ? ya_q : yb_q;
	assign t_lo     = (pt_rd_q < m_ab) ? pt_rd_q : m_ab;
	assign t_hi     = (pt_rd_q > x_ab) ? pt_rd_q : x_ab;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: if (init_q == '1) state_d = S_LOAD;
			S_LOAD: if (accept && last_point) state_d = S_BEGIN;
			S_BEGIN: state_d = S_A_RD;
			S_SW_RD: state_d = S_SW_CHK;
			S_SW_CHK: begin
				if (pd_rd_q != '0) state_d = S_SW_WAIT;
				else state_d = (t_q == '1) ? S_A_RD : S_SW_RD;
			end
			S_SW_WAIT: begin
				if (trsp.done) state_d = (t_q == '1) ? S_A_RD : S_SW_RD;
			end
			S_A_RD: state_d = S_A_GET;
			S_A_GET: begin
				if (a_more) state_d = S_B_RD;
				else state_d = S_CLR;
			end
			S_B_RD: state_d = S_B_GET;
			S_B_GET: begin
				if (triple) begin
					if (b_more) state_d = S_C_RD;
					else state_d = a_more ? S_SW_RD : S_CLR;
				end else if (pair_hit) state_d = S_Q_GO;
				else if (b_more) state_d = S_B_RD;
				else state_d = a_more ? S_SW_RD : S_CLR;
			end
			S_C_RD: state_d = S_C_GET;
			S_C_GET: begin
				if (trip_hit) state_d = S_Q_GO;
				else if (c_more) state_d = S_C_RD;
				else if (b_more) state_d = S_B_RD;
				else state_d = a_more ? S_SW_RD : S_CLR;
			end
			S_Q_GO: state_d = trsp.done ? S_PD_RD : S_Q_WAIT;
			S_Q_WAIT: if (trsp.done) state_d = S_PD_RD;
			S_PD_RD: state_d = S_PD_UPD;
			S_PD_UPD: begin
				if (triple && c_more) state_d = S_C_RD;
				else if (b_more) state_d = S_B_RD;
				else state_d = a_more ? S_SW_RD : S_CLR;
			end
			S_CLR: if (t_q == '1) state_d = S_DONE;
			S_DONE: state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	// Outputs: memory ports, tree commands and result strobe
	always_comb begin
		pt_rd_en   = 1'b0;
		pt_rd_addr = a_q;
		pd_rd_en   = 1'b0;
		pd_rd_addr = {row_prev, t_q};
		pd_we      = 1'b0;
		pd_wr_addr = {row_prev, t_q};
		pd_wr_data = '0;
		tcmd       = '0;
		done       = 1'b0;
		case (state_q)
			S_INIT: begin
				pd_we      = 1'b1;
				pd_wr_addr = init_q;
			end
			S_BEGIN: tcmd.clr = 1'b1;
			S_SW_RD: pd_rd_en = 1'b1;
			S_SW_CHK: begin
				if (pd_rd_q != '0) begin
					pd_we       = 1'b1;
					tcmd.go     = 1'b1;
					tcmd.raise  = 1'b1;
					tcmd.idx    = TIDX_W'(t_q) + TIDX_W'(1);
					tcmd.depth  = pd_rd_q;
				end
			end
			S_A_RD: pt_rd_en = 1'b1;
			S_B_RD: begin
				pt_rd_en   = 1'b1;
				pt_rd_addr = b_q;
			end
			S_C_RD: begin
				pt_rd_en   = 1'b1;
				pt_rd_addr = c_q;
			end
			S_Q_GO: begin
				tcmd.go  = 1'b1;
				tcmd.idx = TIDX_W'(lo_q);
			end
			S_PD_RD: begin
				pd_rd_en   = 1'b1;
				pd_rd_addr = {end_q, hi_q};
			end
			S_PD_UPD: begin
				pd_wr_addr = {end_q, hi_q};
				pd_wr_data = d_q;
				pd_we      = pd_rd_q < d_q;
			end
			S_CLR: begin
				pd_we      = 1'b1;
				pd_wr_addr = {n_last, t_q};
			end
			S_DONE: done = 1'b1;
			default: ;
		endcase
	end

	// Control state, configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			init_q    <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			best_q    <= '0;
			pat_len_q <= RST_PATTERN;
			rank1_q   <= RST_FIRST;
			rank2_q   <= RST_SECOND;
			rank3_q   <= RST_THIRD;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) init_q <= init_q + PEND_AW'(1);
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PATTERN_LENGTH: pat_len_q <= cfg_wdata;
					CFG_FIRST_RANK:     rank1_q   <= cfg_wdata;
					CFG_SECOND_RANK:    rank2_q   <= cfg_wdata;
					CFG_THIRD_RANK:     rank3_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				if (cnt_q < CNT_W'(MAX_POINTS)) cnt_q <= cnt_q + CNT_W'(1);
				else ovf_q <= 1'b1;
			end
			if (state_q == S_BEGIN) best_q <= '0;
			if (state_q == S_PD_UPD && d_q > best_q) best_q <= d_q;
			if (state_q == S_DONE) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Loop indexes and block registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_BEGIN: a_q <= '0;
			S_SW_CHK: if (pd_rd_q == '0) t_q <= t_q + HGT_W'(1);
			S_SW_WAIT: if (trsp.done) t_q <= t_q + HGT_W'(1);
			S_A_GET: begin
				ya_q <= pt_rd_q;
				b_q  <= a_q + IDX_W'(1);
				t_q  <= '0;
			end
			S_B_GET: begin
				yb_q  <= pt_rd_q;
				c_q   <= b_q + IDX_W'(1);
				lo_q  <= p_lo;
				hi_q  <= p_hi;
				end_q <= b_q;
				if (triple || !pair_hit) begin
					if (!triple && b_more) b_q <= b_q + IDX_W'(1);
					if ((triple && !b_more) || (!triple && !b_more)) begin
						a_q <= a_q + IDX_W'(1);
						t_q <= '0;
					end
				end
			end
			S_C_GET: begin
				lo_q  <= t_lo;
				hi_q  <= t_hi;
				end_q <= c_q;
				if (!trip_hit) begin
					if (c_more) c_q <= c_q + IDX_W'(1);
					else if (b_more) b_q <= b_q + IDX_W'(1);
					else begin
						a_q <= a_q + IDX_W'(1);
						t_q <= '0;
					end
				end
			end
			S_Q_GO, S_Q_WAIT: if (trsp.done) d_q <= d_new;
			S_PD_UPD: begin
				if (triple && c_more) c_q <= c_q + IDX_W'(1);
				else if (b_more) b_q <= b_q + IDX_W'(1);
				else begin
					a_q <= a_q + IDX_W'(1);
					t_q <= '0;
				end
			end
			S_CLR: t_q <= t_q + HGT_W'(1);
			default: ;
		endcase
	end

	// Point store
	always_ff @(posedge clk) begin
		if (accept && cnt_q < CNT_W'(MAX_POINTS)) pt_mem[cnt_q[IDX_W-1:0]] <= point_height;
		if (pt_rd_en) pt_rd_q <= pt_mem[pt_rd_addr];
	end

	// Pending depths by end position and top height
	always_ff @(posedge clk) begin
		if (pd_we) pd_mem[pd_wr_addr] <= pd_wr_data;
		if (pd_rd_en) pd_rd_q <= pd_mem[pd_rd_addr];
	end

	pbcl_tree u_tree (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tcmd),
		.rsp    (trsp)
	);

	assign longest_chain   = best_q;
	assign too_many_points = ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond capacity");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && cnt_q == '0 && !ovf_q)
		else $error("load state not cleared after result");
	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(state_q) != S_BEGIN |-> best_q >= $past(best_q))
		else $error("best depth fell during search");
	a_search_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BEGIN |-> cnt_q != '0)
		else $error("search started on empty store");
`endif

endmodule

FILE: test/pattern_block_chain_length_unit_test.sv
// Testbench for the pattern block chain length unit: directed table, then random loads.
module pattern_block_chain_length_unit_test;
	import pbcl_pkg::*;

	typedef struct {
		logic [DEPTH_W-1:0] chain;
		logic               ovf;
	} chain_res_t;

	typedef struct {
		logic [HGT_W-1:0]   h;
		logic               last;
		logic               typed;
		logic [DEPTH_W-1:0] chain;
		logic               ovf;
	} point_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [REG_W-1:0]   cfg_idx = '0;
	logic [REG_W-1:0]   cfg_wdata = '0;
	logic               start = 1'b0;
	logic               busy;
	logic [HGT_W-1:0]   point_height = '0;
	logic               last_point = 1'b0;
	logic               done;
	logic [DEPTH_W-1:0] longest_chain;
	logic               too_many_points;

	pattern_block_chain_length_unit i_dut (.*);

	always #2 clk = ~clk;

	// Local copy of configuration and loaded points
	logic [REG_W-1:0] m_plen = RST_PATTERN, m_r1 = RST_FIRST, m_r2 = RST_SECOND,
		m_r3 = RST_THIRD;
	logic [HGT_W-1:0] loaded_pts[$];
	logic             load_ovf = 1'b0;
	chain_res_t       chain_q[$];
	int               n_errors = 0;
	int               n_items = 0;
	bit               no_gaps = 0;

	// Prefix-max tree and pending depth table for the prediction
	logic [DEPTH_W-1:0] pm_tree[0:HEIGHTS];
	logic [DEPTH_W-1:0] pend_tab[0:MAX_POINTS-1][0:HEIGHTS-1];
	logic [DEPTH_W-1:0] best_chain;

	task automatic report(string what, int got, int want);
		$display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	function automatic logic [1:0] height_rank(int v, int o1, int o2);
		return 2'(1 + (v > o1) + (v > o2));
	endfunction

	function automatic void tree_lift(int ht, logic [DEPTH_W-1:0] d);
		for (int i = ht + 1; i <= HEIGHTS; i += i & -i)
			if (pm_tree[i] < d) pm_tree[i] = d;
	endfunction

	function automatic void add_block(int e, int lo, int hi);
		logic [DEPTH_W-1:0] b;
		logic [DEPTH_W-1:0] d;
		b = '0;
		for (int i = lo; i > 0; i -= i & -i)
			if (pm_tree[i] > b) b = pm_tree[i];
		d = (b == DEPTH_TOP) ? DEPTH_TOP : b + 1'b1;
		if (pend_tab[e][hi] < d) pend_tab[e][hi] = d;
		if (d > best_chain) best_chain = d;
	endfunction

	// Longest chain of pattern blocks over the loaded points
	function automatic logic [DEPTH_W-1:0] chain_search();
		int n;
		int ya, yb, yc, lo, hi;
		n = loaded_pts.size();
		best_chain = '0;
		for (int i = 0; i <= HEIGHTS; i++) pm_tree[i] = '0;
		for (int a = 0; a < n; a++)
			for (int t = 0; t < HEIGHTS; t++) pend_tab[a][t] = '0;
		for (int a = 0; a < n; a++) begin
			if (a > 0)
				for (int t = 0; t < HEIGHTS; t++)
					if (pend_tab[a-1][t] != 0) tree_lift(t, pend_tab[a-1][t]);
			ya = loaded_pts[a];
			for (int b = a + 1; b < n; b++) begin
				yb = loaded_pts[b];
				if (m_plen != PAT_TRIPLE) begin
					if (m_r1 == RANK_DESC ? yb < ya : yb > ya)
						add_block(b, ya < yb ? ya : yb, ya < yb ? yb : ya);
				end else begin
					for (int c = b + 1; c < n; c++) begin
						yc = loaded_pts[c];
						if (height_rank(ya, yb, yc) != m_r1 || height_rank(yb, ya, yc) != m_r2 ||
								height_rank(yc, ya, yb) != m_r3)
							continue;
						lo = ya < yb ? ya : yb;
						if (yc < lo) lo = yc;
						hi = ya > yb ? ya : yb;
						if (yc > hi) hi = yc;
						add_block(c, lo, hi);
					end
				end
			end
		end
		return best_chain;
	endfunction

	// Offer one point and wait until it is taken; start stays high unless a random gap follows
	task automatic send_point(logic [HGT_W-1:0] h, logic last, logic typed = 0,
			logic [DEPTH_W-1:0] tchain = 0, logic tovf = 0);
		chain_res_t r;
		int gap;
		start <= 1'b1;
		point_height <= h;
		last_point <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_items++;
		if (loaded_pts.size() < MAX_POINTS) loaded_pts.push_back(h);
		else load_ovf = 1'b1;
		if (last) begin
			r.chain = chain_search();
			r.ovf = load_ovf;
			if (typed) begin
				r.chain = tchain;
				r.ovf = tovf;
			end
			chain_q.push_back(r);
			loaded_pts.delete();
			load_ovf = 1'b0;
		end
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register write once the unit is idle and all results are back
	task automatic write_reg(logic [REG_W-1:0] idx, logic [REG_W-1:0] val);
		start <= 1'b0;
		@(posedge clk);
		while (busy || chain_q.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PATTERN_LENGTH: m_plen = val;
			CFG_FIRST_RANK:     m_r1 = val;
			CFG_SECOND_RANK:    m_r2 = val;
			default:            m_r3 = val;
		endcase
	endtask

	// One random load: near-sorted or reversed run, small-range heights or plain random heights
	task automatic send_load(int n);
		logic [HGT_W-1:0] hs[$];
		int kind, j;
		logic [HGT_W-1:0] tmp;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < n; i++) hs.push_back(HGT_W'($urandom()));
		if (kind < 4) begin
			hs.sort();
			for (int i = 0; i < n / 2; i++) begin
				j = $urandom_range(0, n - 1);
				tmp = hs[j];
				hs[j] = hs[(j + 1) % n];
				hs[(j + 1) % n] = tmp;
			end
			if (kind == 0) hs.reverse();
		end else if (kind < 8) begin
			for (int i = 0; i < n; i++) hs[i] = HGT_W'($urandom_range(0, 15));
		end
		for (int i = 0; i < n; i++) send_point(hs[i], i == n - 1);
	endtask

	// Result checker: every done strobe against the oldest expectation
	always @(posedge clk) begin
		chain_res_t e;
		if (done) begin
			if (chain_q.size() == 0) begin
				report("unexpected result", longest_chain, -1);
			end else begin
				e = chain_q.pop_front();
				if (longest_chain !== e.chain) report("longest_chain", longest_chain, e.chain);
				if (too_many_points !== e.ovf) report("too_many_points", too_many_points, e.ovf);
			end
		end
	end

	initial begin
		#40000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		point_row_t dir_tab[$];
		logic [REG_W-1:0] phases[$][4];
		int ph;
		dir_tab = '{
			'{8'd5,   1, 1, 0, 0},
			'{8'd200, 0, 1, 0, 0}, '{8'd10,  1, 1, 1, 0},
			'{8'd10,  0, 1, 0, 0}, '{8'd200, 1, 1, 0, 0},
			'{8'd255, 0, 1, 0, 0}, '{8'd0,   1, 1, 1, 0},
			'{8'd0,   0, 1, 0, 0}, '{8'd0,   1, 1, 0, 0},
			'{8'd170, 0, 0, 0, 0}, '{8'd85,  0, 0, 0, 0}, '{8'd255, 0, 0, 0, 0},
			'{8'd100, 0, 0, 0, 0}, '{8'd1,   1, 0, 0, 0},
			'{8'd4,   0, 0, 0, 0}, '{8'd3,   0, 0, 0, 0}, '{8'd2,   0, 0, 0, 0},
			'{8'd1,   1, 0, 0, 0}
		};
		phases = '{
			'{2'd2, 2'd1, 2'd1, 2'd3}, '{2'd0, 2'd2, 2'd0, 2'd0},
			'{2'd1, 2'd3, 2'd3, 2'd3}, '{2'd3, 2'd2, 2'd1, 2'd3},
			'{2'd3, 2'd1, 2'd2, 2'd3}, '{2'd3, 2'd3, 2'd2, 2'd1},
			'{2'd3, 2'd1, 2'd3, 2'd2}, '{2'd3, 2'd0, 2'd1, 2'd2},
			'{2'd3, 2'd1, 2'd1, 2'd3}, '{2'd3, 2'd2, 2'd2, 2'd2},
			'{2'd2, 2'd2, 2'd1, 2'd3}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with reset configuration (descending pairs)
		foreach (dir_tab[i])
			send_point(dir_tab[i].h, dir_tab[i].last, dir_tab[i].typed,
				dir_tab[i].chain, dir_tab[i].ovf);

		// Random part, phase by phase through the register settings
		ph = 0;
		while (n_items < 1050) begin
			for (int r = 0; r < 4; r++) write_reg(REG_W'(r), phases[ph][r]);
			no_gaps = ($urandom_range(0, 3) == 0);
			if (ph == 0 && n_items < 200) begin
				// capacity overflow, last point dropped too
				send_load(MAX_POINTS + 2);
			end
			for (int l = 0; l < 12; l++)
				send_load(phases[ph][0] == PAT_TRIPLE ?
					($urandom_range(0, 7) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 7)) :
					($urandom_range(0, 7) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 7)));
			ph = (ph + 1) % phases.size();
		end

		start <= 1'b0;
		@(posedge clk);
		while (chain_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/pbcl_pkg.sv
rtl/core/pbcl_tree.sv
rtl/core/pattern_block_chain_length_unit.sv
test/pattern_block_chain_length_unit_test.sv
